FILE: sv/ecp_pkg.sv
package ecp_pkg;

    // Field widths
    localparam int TIME_W  = 24;
    localparam int CURVE_W = 5;
    localparam int OUT_W   = 18;
    localparam int FRAC_W  = 16;
    localparam int VAL_W   = 34;
    localparam int X_W     = 18;
    localparam int CNT_W   = 5;

    // Fixed-point constants (Q16 unless the name says Q30 or Q32)
    localparam logic signed [VAL_W-1:0] QONE   = 34'sd65536;
    localparam logic signed [VAL_W-1:0] TWO_Q  = 34'sd131072;
    localparam logic [63:0] BACK_S_Q32  = 64'd7308230452;
    localparam logic [63:0] BACK_S2_Q32 = 64'd11145051439;
    localparam logic signed [VAL_W-1:0] BACK_S  = VAL_W'((BACK_S_Q32 + 64'd32768) >> 16);
    localparam logic signed [VAL_W-1:0] BACK_S2 = VAL_W'((BACK_S2_Q32 + 64'd32768) >> 16);
    localparam logic signed [VAL_W-1:0] LN2_Q30 = 34'sd744261118;
    localparam logic signed [VAL_W-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [VAL_W-1:0] Y_MIN   = -34'sd65536;
    localparam logic signed [VAL_W-1:0] Y_MAX   = 34'sd131071;

    // Step counts (last counter value)
    localparam logic [CNT_W-1:0] DIV_LAST   = 5'd15;
    localparam logic [CNT_W-1:0] ROOT_LAST  = 5'd16;
    localparam logic [CNT_W-1:0] XSTEP_LAST = 5'd7;

    // Curve families; poly families equal their in-out scale shift
    localparam logic [2:0] FAM_LIN   = 3'd0;
    localparam logic [2:0] FAM_QUAD  = 3'd1;
    localparam logic [2:0] FAM_CUBIC = 3'd2;
    localparam logic [2:0] FAM_QUART = 3'd3;
    localparam logic [2:0] FAM_QUINT = 3'd4;
    localparam logic [2:0] FAM_CIRC  = 3'd5;
    localparam logic [2:0] FAM_EXPO  = 3'd6;
    localparam logic [2:0] FAM_BACK  = 3'd7;

    localparam logic [1:0] FORM_IN    = 2'd0;
    localparam logic [1:0] FORM_OUT   = 2'd1;
    localparam logic [1:0] FORM_INOUT = 2'd2;

    // Datapath operations
    localparam logic [4:0] OP_NONE  = 5'd0;
    localparam logic [4:0] OP_START = 5'd1;
    localparam logic [4:0] OP_DIV   = 5'd2;
    localparam logic [4:0] OP_BASE  = 5'd3;
    localparam logic [4:0] OP_POW   = 5'd4;
    localparam logic [4:0] OP_QOUT  = 5'd5;
    localparam logic [4:0] OP_SQR   = 5'd6;
    localparam logic [4:0] OP_RINIT = 5'd7;
    localparam logic [4:0] OP_RSTEP = 5'd8;
    localparam logic [4:0] OP_XSTEP = 5'd9;
    localparam logic [4:0] OP_XLN   = 5'd10;
    localparam logic [4:0] OP_XLIN  = 5'd11;
    localparam logic [4:0] OP_XSH   = 5'd12;
    localparam logic [4:0] OP_BK2   = 5'd13;
    localparam logic [4:0] OP_BK3   = 5'd14;
    localparam logic [4:0] OP_BK4   = 5'd15;
    localparam logic [4:0] OP_FINAL = 5'd16;
    localparam logic [4:0] OP_LOAD  = 5'd17;

    typedef struct packed {
        logic [2:0] fam;
        logic [1:0] form;
    } curve_info_t;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic act;
    } dp_stat_t;

    // Curve code to family and form; unknown codes are linear
    function automatic curve_info_t curve_decode(input logic [CURVE_W-1:0] c);
        curve_info_t ci;
        ci.fam  = FAM_LIN;
        ci.form = FORM_IN;
        unique case (c)
            5'd1:    begin ci.fam = FAM_QUAD;  ci.form = FORM_IN;    end
            5'd2:    begin ci.fam = FAM_QUAD;  ci.form = FORM_OUT;   end
            5'd3:    begin ci.fam = FAM_QUAD;  ci.form = FORM_INOUT; end
            5'd4:    begin ci.fam = FAM_CUBIC; ci.form = FORM_IN;    end
            5'd5:    begin ci.fam = FAM_CUBIC; ci.form = FORM_OUT;   end
            5'd6:    begin ci.fam = FAM_CUBIC; ci.form = FORM_INOUT; end
            5'd7:    begin ci.fam = FAM_QUART; ci.form = FORM_IN;    end
            5'd8:    begin ci.fam = FAM_QUART; ci.form = FORM_OUT;   end
            5'd9:    begin ci.fam = FAM_QUART; ci.form = FORM_INOUT; end
            5'd10:   begin ci.fam = FAM_QUINT; ci.form = FORM_IN;    end
            5'd11:   begin ci.fam = FAM_QUINT; ci.form = FORM_OUT;   end
            5'd12:   begin ci.fam = FAM_QUINT; ci.form = FORM_INOUT; end
            5'd13:   begin ci.fam = FAM_CIRC;  ci.form = FORM_IN;    end
            5'd14:   begin ci.fam = FAM_CIRC;  ci.form = FORM_OUT;   end
            5'd15:   begin ci.fam = FAM_CIRC;  ci.form = FORM_INOUT; end
            5'd16:   begin ci.fam = FAM_EXPO;  ci.form = FORM_IN;    end
            5'd17:   begin ci.fam = FAM_EXPO;  ci.form = FORM_OUT;   end
            5'd18:   begin ci.fam = FAM_EXPO;  ci.form = FORM_INOUT; end
            5'd19:   begin ci.fam = FAM_BACK;  ci.form = FORM_IN;    end
            5'd20:   begin ci.fam = FAM_BACK;  ci.form = FORM_OUT;   end
            5'd21:   begin ci.fam = FAM_BACK;  ci.form = FORM_INOUT; end
            default: begin ci.fam = FAM_LIN;   ci.form = FORM_IN;    end
        endcase
        return ci;
    endfunction

    // 2^(-2^-(b+1)) in Q30
    function automatic logic [VAL_W-1:0] pow2neg(input logic [2:0] b);
        logic [VAL_W-1:0] v;
        unique case (b)
            3'd0: v = 34'd759250125;
            3'd1: v = 34'd902905651;
            3'd2: v = 34'd984625594;
            3'd3: v = 34'd1028218693;
            3'd4: v = 34'd1050733751;
            3'd5: v = 34'd1062175491;
            3'd6: v = 34'd1067942999;
            3'd7: v = 34'd1070838486;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/ecp_ctrl.sv
module ecp_ctrl import ecp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic [CURVE_W-1:0]  easing_curve,
    input  dp_stat_t            stat,
    output dp_cmd_t             cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_DIV   = 5'd2;
    localparam logic [4:0] S_BASE  = 5'd3;
    localparam logic [4:0] S_POW   = 5'd4;
    localparam logic [4:0] S_QOUT  = 5'd5;
    localparam logic [4:0] S_SQR   = 5'd6;
    localparam logic [4:0] S_RINIT = 5'd7;
    localparam logic [4:0] S_RSTEP = 5'd8;
    localparam logic [4:0] S_XSTEP = 5'd9;
    localparam logic [4:0] S_XLN   = 5'd10;
    localparam logic [4:0] S_XLIN  = 5'd11;
    localparam logic [4:0] S_XSH   = 5'd12;
    localparam logic [4:0] S_BK2   = 5'd13;
    localparam logic [4:0] S_BK3   = 5'd14;
    localparam logic [4:0] S_BK4   = 5'd15;
    localparam logic [4:0] S_FINAL = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    curve_info_t      ci;

    assign ci        = curve_decode(easing_curve);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg[2:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_START;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cnt_next   = '0;
                state_next = stat.act ? S_DIV : S_FINAL;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_BASE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_BASE:
            begin
                cmd.op   = OP_BASE;
                cnt_next = '0;
                unique case (ci.fam)
                    FAM_LIN:   state_next = S_FINAL;
                    FAM_QUAD:  state_next = (ci.form == FORM_OUT) ? S_QOUT : S_POW;
                    FAM_CUBIC: state_next = S_POW;
                    FAM_QUART: state_next = S_POW;
                    FAM_QUINT: state_next = S_POW;
                    FAM_CIRC:  state_next = S_SQR;
                    FAM_EXPO:  state_next = S_XSTEP;
                    FAM_BACK:  state_next = S_SQR;
                endcase
            end
            S_QOUT:
            begin
                cmd.op     = OP_QOUT;
                state_next = S_FINAL;
            end
            S_POW:
            begin
                cmd.op = OP_POW;
                // power n takes n-1 products; family code equals n-1
                if (cnt_reg[2:0] == ci.fam - 3'd1)
                    state_next = S_FINAL;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_SQR:
            begin
                cmd.op     = OP_SQR;
                state_next = (ci.fam == FAM_CIRC) ? S_RINIT : S_BK2;
            end
            S_RINIT:
            begin
                cmd.op     = OP_RINIT;
                cnt_next   = '0;
                state_next = S_RSTEP;
            end
            S_RSTEP:
            begin
                cmd.op = OP_RSTEP;
                if (cnt_reg == ROOT_LAST)
                    state_next = S_FINAL;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_XSTEP:
            begin
                cmd.op = OP_XSTEP;
                if (cnt_reg == XSTEP_LAST)
                    state_next = S_XLN;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_XLN:
            begin
                cmd.op     = OP_XLN;
                state_next = S_XLIN;
            end
            S_XLIN:
            begin
                cmd.op     = OP_XLIN;
                state_next = S_XSH;
            end
            S_XSH:
            begin
                cmd.op     = OP_XSH;
                state_next = S_FINAL;
            end
            S_BK2:
            begin
                cmd.op     = OP_BK2;
                state_next = S_BK3;
            end
            S_BK3:
            begin
                cmd.op     = OP_BK3;
                state_next = S_BK4;
            end
            S_BK4:
            begin
                cmd.op     = OP_BK4;
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.op     = OP_FINAL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        if (cmd.op == OP_LOAD)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CHK))
        else $error("accepted item did not start processing");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= DIV_LAST))
        else $error("divider step count out of range");

    a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RSTEP) |-> (cnt_reg <= ROOT_LAST))
        else $error("square root step count out of range");
`endif

endmodule

FILE: sv/ecp_dp.sv
module ecp_dp import ecp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    input  logic [TIME_W-1:0]         elapsed_time,
    input  logic [TIME_W-1:0]         duration_ticks,
    input  logic [TIME_W-1:0]         delay_ticks,
    input  logic [CURVE_W-1:0]        easing_curve,
    output logic                      active,
    output logic                      finished,
    output logic signed [OUT_W-1:0]   eased_progress
);

    logic [TIME_W-1:0]        rem_reg, rem_next;
    logic [FRAC_W-1:0]        p_reg, p_next;
    logic [X_W-1:0]           x_reg, x_next;
    logic signed [VAL_W-1:0]  acc_reg, acc_next;
    logic signed [VAL_W-1:0]  t1_reg, t1_next;
    logic [3:0]               k_reg, k_next;
    logic [FRAC_W-1:0]        f_reg, f_next;
    logic [VAL_W-1:0]         sq_rem_reg, sq_rem_next;
    logic [VAL_W-1:0]         sq_res_reg, sq_res_next;
    logic [VAL_W-1:0]         sq_bit_reg, sq_bit_next;
    logic                     act_reg, act_next;
    logic                     done_reg, done_next;
    logic signed [OUT_W-1:0]  y_reg, y_next;
    logic                     active_reg;
    logic                     finished_reg;
    logic signed [OUT_W-1:0]  eased_reg;

    curve_info_t              ci;
    logic                     low;
    logic [16:0]              u_val;
    logic [16:0]              q_val;
    logic [17:0]              v_val;
    logic [X_W-1:0]           x_sel;
    logic [20:0]              ten_x;
    logic signed [VAL_W-1:0]  x_s;
    logic signed [VAL_W-1:0]  p_s;
    logic signed [VAL_W-1:0]  ma, mb;
    logic signed [2*VAL_W-1:0] prod;
    logic signed [2*VAL_W-1:0] r16_w, r30_w;
    logic signed [VAL_W-1:0]  r16, r30;
    logic signed [VAL_W-1:0]  cval, cplus;
    logic                     in_like;
    logic [TIME_W-1:0]        diff;
    logic                     after, in_win;
    logic [TIME_W:0]          rem2;
    logic [VAL_W-1:0]         trial;
    logic signed [VAL_W-1:0]  d_s;
    logic [4:0]               xs_amt, xs_rnd;
    logic signed [VAL_W-1:0]  acc_k;
    logic signed [VAL_W-1:0]  r_s;
    logic signed [VAL_W-1:0]  y_full;

    assign ci    = curve_decode(easing_curve);
    assign low   = ~p_reg[FRAC_W-1];
    assign u_val = 17'h10000 - {1'b0, p_reg};
    assign q_val = {p_reg, 1'b0};
    assign v_val = {u_val, 1'b0};
    assign x_s   = $signed({{(VAL_W-X_W){1'b0}}, x_reg});
    assign p_s   = $signed({{(VAL_W-FRAC_W){1'b0}}, p_reg});
    assign cval  = (ci.form == FORM_INOUT) ? BACK_S2 : BACK_S;
    assign cplus = cval + QONE;
    assign in_like = (ci.form == FORM_IN) || ((ci.form == FORM_INOUT) && low);
    assign stat.act = act_reg;

    // Window test and progress numerator
    assign after  = elapsed_time > delay_ticks;
    assign diff   = elapsed_time - delay_ticks;
    assign in_win = after && (diff < duration_ticks);

    // Curve argument
    always_comb
    begin
        x_sel = {2'b0, p_reg};
        unique case (ci.fam)
            FAM_LIN:
                x_sel = {2'b0, p_reg};
            FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT:
            begin
                if (ci.fam == FAM_QUAD && ci.form == FORM_OUT)
                    x_sel = {2'b0, p_reg};
                else if (ci.form == FORM_OUT || (ci.form == FORM_INOUT && !low))
                    x_sel = {1'b0, u_val};
                else
                    x_sel = {2'b0, p_reg};
            end
            FAM_CIRC, FAM_BACK:
            begin
                if (ci.form == FORM_OUT)
                    x_sel = {1'b0, u_val};
                else if (ci.form == FORM_INOUT)
                    x_sel = low ? {1'b0, q_val} : v_val;
                else
                    x_sel = {2'b0, p_reg};
            end
            FAM_EXPO:
            begin
                if (ci.form == FORM_IN)
                    x_sel = {1'b0, u_val};
                else if (ci.form == FORM_OUT)
                    x_sel = {2'b0, p_reg};
                else if (low)
                    x_sel = {1'b0, 17'h10000 - q_val};
                else
                    x_sel = {1'b0, q_val - 17'h10000};
            end
        endcase
    end

    // Expo exponent 10*x split into integer and fraction
    assign ten_x = {x_sel, 3'b0} + {2'b0, x_sel, 1'b0};

    // Shared multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            OP_POW:   begin ma = acc_reg; mb = x_s;              end
            OP_QOUT:  begin ma = x_s;     mb = TWO_Q - x_s;      end
            OP_SQR:   begin ma = x_s;     mb = x_s;              end
            OP_BK2:   begin ma = cplus;   mb = x_s;              end
            OP_BK4:   begin ma = t1_reg;  mb = acc_reg;          end
            OP_XSTEP: begin ma = acc_reg; mb = $signed(pow2neg(cmd.idx)); end
            OP_XLN:   begin ma = LN2_Q30; mb = $signed({26'b0, f_reg[7:0]}); end
            OP_XLIN:  begin ma = acc_reg; mb = t1_reg;           end
            default:  begin ma = '0;      mb = '0;               end
        endcase
    end

    assign prod  = ma * mb;
    assign r16_w = (prod + 68'sd32768) >>> 16;
    assign r30_w = (prod + 68'sd536870912) >>> 30;
    assign r16   = r16_w[VAL_W-1:0];
    assign r30   = r30_w[VAL_W-1:0];

    // Misc step terms
    assign rem2   = {rem_reg, 1'b0};
    assign trial  = sq_res_reg + sq_bit_reg;
    assign d_s    = QONE - t1_reg;
    assign xs_amt = 5'd14 + {1'b0, k_reg};
    assign xs_rnd = 5'd13 + {1'b0, k_reg};

    // Final curve combine
    assign acc_k = acc_reg <<< ci.fam;
    assign r_s   = $signed(sq_res_reg);

    always_comb
    begin
        y_full = p_s;
        unique case (ci.fam)
            FAM_LIN:
                y_full = p_s;
            FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT:
            begin
                if (ci.fam == FAM_QUAD && ci.form == FORM_OUT)
                    y_full = acc_reg;
                else if (ci.form == FORM_OUT)
                    y_full = QONE - acc_reg;
                else if (ci.form == FORM_INOUT)
                    y_full = low ? acc_k : QONE - acc_k;
                else
                    y_full = acc_reg;
            end
            FAM_CIRC:
            begin
                if (ci.form == FORM_OUT)
                    y_full = r_s;
                else if (ci.form == FORM_INOUT)
                    y_full = low ? (QONE - r_s) >>> 1 : (r_s + QONE) >>> 1;
                else
                    y_full = QONE - r_s;
            end
            FAM_EXPO:
            begin
                if (ci.form == FORM_OUT)
                    y_full = QONE - acc_reg;
                else if (p_reg == '0)
                    y_full = '0;
                else if (ci.form == FORM_INOUT)
                    y_full = low ? acc_reg >>> 1 : (TWO_Q - acc_reg) >>> 1;
                else
                    y_full = acc_reg;
            end
            FAM_BACK:
            begin
                if (ci.form == FORM_OUT)
                    y_full = QONE + acc_reg;
                else if (ci.form == FORM_INOUT)
                    y_full = low ? acc_reg >>> 1 : (acc_reg + TWO_Q) >>> 1;
                else
                    y_full = acc_reg;
            end
        endcase
    end

    // Operation decode
    always_comb
    begin
        rem_next    = rem_reg;
        p_next      = p_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        t1_next     = t1_reg;
        k_next      = k_reg;
        f_next      = f_reg;
        sq_rem_next = sq_rem_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        act_next    = act_reg;
        done_next   = done_reg;
        y_next      = y_reg;
        unique case (cmd.op)
            OP_START:
            begin
                act_next  = in_win;
                done_next = done_reg | (after & ~in_win);
                rem_next  = diff;
                p_next    = '0;
            end
            OP_DIV:
            begin
                if (rem2 >= {1'b0, duration_ticks})
                begin
                    rem_next = TIME_W'(rem2 - {1'b0, duration_ticks});
                    p_next   = {p_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[TIME_W-1:0];
                    p_next   = {p_reg[FRAC_W-2:0], 1'b0};
                end
            end
            OP_BASE:
            begin
                x_next   = x_sel;
                acc_next = (ci.fam == FAM_EXPO) ? ONE_Q30
                                                : $signed({{(VAL_W-X_W){1'b0}}, x_sel});
                k_next   = ten_x[19:16];
                f_next   = ten_x[15:0];
            end
            OP_POW, OP_QOUT, OP_BK4:
                acc_next = r16;
            OP_SQR:
                t1_next = r16;
            OP_BK2:
                acc_next = r16;
            OP_BK3:
                acc_next = in_like ? acc_reg - cval : cval - acc_reg;
            OP_RINIT:
            begin
                sq_rem_next = d_s[VAL_W-1] ? '0 : {d_s[17:0], 16'b0};
                sq_res_next = '0;
                sq_bit_next = 34'h1_0000_0000;
            end
            OP_RSTEP:
            begin
                if (sq_rem_reg >= trial)
                begin
                    sq_rem_next = sq_rem_reg - trial;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
            end
            OP_XSTEP:
            begin
                if (f_reg[4'd15 - {1'b0, cmd.idx}])
                    acc_next = r30;
            end
            OP_XLN:
                t1_next = ONE_Q30 - r16;
            OP_XLIN:
                acc_next = r30;
            OP_XSH:
                acc_next = (acc_reg + (34'sd1 <<< xs_rnd)) >>> xs_amt;
            OP_FINAL:
            begin
                if (!act_reg)
                    y_next = '0;
                else if (y_full < Y_MIN)
                    y_next = Y_MIN[OUT_W-1:0];
                else if (y_full > Y_MAX)
                    y_next = Y_MAX[OUT_W-1:0];
                else
                    y_next = y_full[OUT_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            act_reg  <= act_next;
            done_reg <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        p_reg      <= p_next;
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        t1_reg     <= t1_next;
        k_reg      <= k_next;
        f_reg      <= f_next;
        sq_rem_reg <= sq_rem_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        y_reg      <= y_next;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            active_reg   <= act_reg;
            finished_reg <= done_reg;
            eased_reg    <= y_reg;
        end
    end

    assign active         = active_reg;
    assign finished       = finished_reg;
    assign eased_progress = eased_reg;

endmodule

FILE: sv/easing_curve_progress.sv
// Easing curve progress: each item carries an elapsed tick count; the block
// returns active (time strictly between delay and delay + duration), a sticky
// finished flag, and the eased progress in signed Q16 saturated to
// [-65536, 131071]. Configure duration (0x0), delay (0x4) and curve (0x8)
// through the APB port while idle. An item outside the window goes from the
// window check straight to the final step and has its result loaded. Inside
// the window a one-bit-per-cycle divider forms the progress, a shared 34x34
// multiplier runs the curve products one per cycle, and the square root for
// the circ curves retires two bits per cycle. The next item is taken in the
// cycle after the load. A new item is taken while the previous result waits
// in the output register.
module easing_curve_progress import ecp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [TIME_W-1:0]        elapsed_time,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     active,
    output logic                     finished,
    output logic signed [OUT_W-1:0]  eased_progress
);

    localparam logic [1:0] REG_DURATION = 2'd0;
    localparam logic [1:0] REG_DELAY    = 2'd1;
    localparam logic [1:0] REG_CURVE    = 2'd2;

    logic [TIME_W-1:0]  dur_reg;
    logic [TIME_W-1:0]  del_reg;
    logic [CURVE_W-1:0] curve_reg;
    logic               wr_en;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg   <= 24'd1;
            del_reg   <= '0;
            curve_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DURATION: dur_reg   <= pwdata[TIME_W-1:0];
                REG_DELAY:    del_reg   <= pwdata[TIME_W-1:0];
                REG_CURVE:    curve_reg <= pwdata[CURVE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_DURATION: prdata = {8'b0, dur_reg};
            REG_DELAY:    prdata = {8'b0, del_reg};
            REG_CURVE:    prdata = {27'b0, curve_reg};
            default:      prdata = '0;
        endcase
    end

    ecp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .easing_curve (curve_reg),
        .stat         (stat),
        .cmd          (cmd)
    );

    ecp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .elapsed_time   (elapsed_time),
        .duration_ticks (dur_reg),
        .delay_ticks    (del_reg),
        .easing_curve   (curve_reg),
        .active         (active),
        .finished       (finished),
        .eased_progress (eased_progress)
    );

endmodule

FILE: tb/easing_curve_progress_test.sv
`timescale 1ns / 100ps

module easing_curve_progress_test;
    import ecp_pkg::*;

    // Curve select codes
    typedef enum logic [4:0] {
        CRV_LINEAR = 5'd0,
        CRV_QUAD_IN = 5'd1, CRV_QUAD_OUT = 5'd2, CRV_QUAD_INOUT = 5'd3,
        CRV_CUBIC_IN = 5'd4, CRV_CUBIC_OUT = 5'd5, CRV_CUBIC_INOUT = 5'd6,
        CRV_QUART_IN = 5'd7, CRV_QUART_OUT = 5'd8, CRV_QUART_INOUT = 5'd9,
        CRV_QUINT_IN = 5'd10, CRV_QUINT_OUT = 5'd11, CRV_QUINT_INOUT = 5'd12,
        CRV_CIRC_IN = 5'd13, CRV_CIRC_OUT = 5'd14, CRV_CIRC_INOUT = 5'd15,
        CRV_EXPO_IN = 5'd16, CRV_EXPO_OUT = 5'd17, CRV_EXPO_INOUT = 5'd18,
        CRV_BACK_IN = 5'd19, CRV_BACK_OUT = 5'd20, CRV_BACK_INOUT = 5'd21,
        CRV_UNKNOWN = 5'd31
    } curve_e;

    // Register indexes
    localparam int REG_DURATION = 0;
    localparam int REG_DELAY    = 1;
    localparam int REG_CURVE    = 2;

    localparam longint ONE_Q  = 65536;
    localparam longint TMAX   = 24'hFFFFFF;
    localparam longint S_Q16  = (64'd7308230452 + 64'd32768) >> 16;
    localparam longint S2_Q16 = (64'd11145051439 + 64'd32768) >> 16;
    localparam longint unsigned LN2_Q30V = 64'd744261118;
    localparam longint unsigned EXP_STEP [8] = '{
        64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
        64'd1050733751, 64'd1062175491, 64'd1067942999, 64'd1070838486};

    typedef struct packed {
        logic                    act;
        logic                    fin;
        logic signed [OUT_W-1:0] y;
    } frame_t;

    typedef struct {
        longint dur;
        longint dly;
        curve_e crv;
        longint tm;
        bit     typed;
        frame_t res;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready;
    logic [TIME_W-1:0] elapsed_time;
    logic out_valid, out_ready;
    logic active, finished;
    logic signed [OUT_W-1:0] eased_progress;

    easing_curve_progress i_dut (.*);

    // Shadow of the block's registers and sticky flag
    longint sh_dur, sh_dly;
    logic [4:0] sh_crv;
    bit sh_done;

    frame_t frame_q[$];
    bit     use_typed;
    frame_t typed_frame;
    bit     quiet;
    int     n_err, n_frames, n_items;
    int     stall_left;

    always #1 clk = ~clk;

    function automatic longint qmul(longint a, longint b);
        return (a * b + (ONE_Q >>> 1)) >>> 16;
    endfunction

    function automatic longint qpow(longint x, int n);
        longint r;
        r = x;
        for (int i = 1; i < n; i++)
            r = qmul(r, x);
        return r;
    endfunction

    // Floor square root of x in Q16 (32 two-bit steps)
    function automatic longint qsqrt(longint x);
        longint unsigned rem, res, bt;
        res = 0;
        bt = 64'd1 << 62;
        if (x < 0)
            x = 0;
        rem = longint'(x) << 16;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bt)
            begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return longint'(res);
    endfunction

    // 2^-m, m in Q16, via Q30 table and linear tail
    function automatic longint exp_neg(longint mv);
        longint unsigned m, k, f, acc, r, lin, s;
        m = mv;
        k = m >> 16;
        f = m & 64'hFFFF;
        acc = 64'd1 << 30;
        for (int b = 0; b < 8; b++)
            if ((f >> (15 - b)) & 1)
                acc = (acc * EXP_STEP[b] + (64'd1 << 29)) >> 30;
        r = f & 64'hFF;
        lin = (64'd1 << 30) - ((LN2_Q30V * r + (64'd1 << 15)) >> 16);
        acc = (acc * lin + (64'd1 << 29)) >> 30;
        if (k > 40)
            return 0;
        s = 14 + k;
        return longint'((acc + (64'd1 << (s - 1))) >> s);
    endfunction

    function automatic longint apply_curve(logic [4:0] c, longint p);
        longint u, h, q, v;
        u = ONE_Q - p;
        h = ONE_Q >>> 1;
        q = 2 * p;
        v = 2 * u;
        case (c)
            CRV_QUAD_IN:     return qmul(p, p);
            CRV_QUAD_OUT:    return qmul(p, 2 * ONE_Q - p);
            CRV_QUAD_INOUT:  return p < h ? 2 * qpow(p, 2) : ONE_Q - 2 * qpow(u, 2);
            CRV_CUBIC_IN:    return qpow(p, 3);
            CRV_CUBIC_OUT:   return ONE_Q - qpow(u, 3);
            CRV_CUBIC_INOUT: return p < h ? 4 * qpow(p, 3) : ONE_Q - 4 * qpow(u, 3);
            CRV_QUART_IN:    return qpow(p, 4);
            CRV_QUART_OUT:   return ONE_Q - qpow(u, 4);
            CRV_QUART_INOUT: return p < h ? 8 * qpow(p, 4) : ONE_Q - 8 * qpow(u, 4);
            CRV_QUINT_IN:    return qpow(p, 5);
            CRV_QUINT_OUT:   return ONE_Q - qpow(u, 5);
            CRV_QUINT_INOUT: return p < h ? 16 * qpow(p, 5) : ONE_Q - 16 * qpow(u, 5);
            CRV_CIRC_IN:     return ONE_Q - qsqrt(ONE_Q - qmul(p, p));
            CRV_CIRC_OUT:    return qsqrt(ONE_Q - qmul(u, u));
            CRV_CIRC_INOUT:
                if (q < ONE_Q)
                    return (ONE_Q - qsqrt(ONE_Q - qmul(q, q))) >>> 1;
                else
                    return (qsqrt(ONE_Q - qmul(v, v)) + ONE_Q) >>> 1;
            CRV_EXPO_IN:     return p == 0 ? 0 : exp_neg(10 * u);
            CRV_EXPO_OUT:    return ONE_Q - exp_neg(10 * p);
            CRV_EXPO_INOUT:
                if (p == 0)
                    return 0;
                else if (q < ONE_Q)
                    return exp_neg(10 * (ONE_Q - q)) >>> 1;
                else
                    return (2 * ONE_Q - exp_neg(10 * (q - ONE_Q))) >>> 1;
            CRV_BACK_IN:     return qmul(qmul(p, p), qmul(S_Q16 + ONE_Q, p) - S_Q16);
            CRV_BACK_OUT:    return ONE_Q + qmul(qmul(u, u), S_Q16 - qmul(S_Q16 + ONE_Q, u));
            CRV_BACK_INOUT:
                if (q < ONE_Q)
                    return qmul(qmul(q, q), qmul(S2_Q16 + ONE_Q, q) - S2_Q16) >>> 1;
                else
                    return (qmul(qmul(v, v), S2_Q16 - qmul(S2_Q16 + ONE_Q, v))
                            + 2 * ONE_Q) >>> 1;
            default:         return p;
        endcase
    endfunction

    // Next frame for one time value; updates the sticky flag
    function automatic frame_t predict_frame(longint t);
        frame_t f;
        longint y;
        f = '0;
        y = 0;
        if (t > sh_dly)
        begin
            if (t < sh_dly + sh_dur && sh_dur != 0)
                f.act = 1'b1;
            else
                sh_done = 1'b1;
        end
        if (f.act)
        begin
            y = apply_curve(sh_crv, ((t - sh_dly) << 16) / sh_dur);
            if (y < -65536)
                y = -65536;
            if (y > 131071)
                y = 131071;
        end
        f.fin = sh_done;
        f.y = y[OUT_W-1:0];
        return f;
    endfunction

    // Accepted items -> expected frames
    always @(posedge clk)
    begin
        frame_t f;
        if (in_valid && in_ready)
        begin
            f = predict_frame(longint'(elapsed_time));
            if (use_typed)
                f = typed_frame;
            frame_q.push_back(f);
            n_items++;
        end
    end

    // Returned frames vs. oldest expectation
    always @(posedge clk)
    begin
        frame_t e;
        if (out_valid && out_ready)
        begin
            n_frames++;
            if (frame_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected frame act=%0b fin=%0b y=%0d",
                             active, finished, eased_progress);
            end
            else
            begin
                e = frame_q.pop_front();
                if (e.act !== active || e.fin !== finished || e.y !== eased_progress)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: frame exp act=%0b fin=%0b y=%0d got act=%0b fin=%0b y=%0d",
                                 e.act, e.fin, e.y, active, finished, eased_progress);
                end
            end
        end
    end

    // Receiver stalls in bursts
    always @(negedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Wait for drain plus the longest item latency
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (frame_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic reg_write(int idx, longint val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(4 * idx);
        pwdata <= 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DURATION: sh_dur = val & TMAX;
            REG_DELAY:    sh_dly = val & TMAX;
            default:      sh_crv = 5'(val);
        endcase
    endtask

    task automatic set_timing(longint dur, longint dly, logic [4:0] crv);
        wait_idle();
        if (dur != sh_dur)
            reg_write(REG_DURATION, dur);
        if (dly != sh_dly)
            reg_write(REG_DELAY, dly);
        if (crv != sh_crv)
            reg_write(REG_CURVE, crv);
    endtask

    // One item; called at a falling edge, returns at a falling edge
    task automatic send_time(longint t);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        elapsed_time <= 24'(t);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic longint pick_time();
        longint hi;
        int sel;
        sel = $urandom_range(0, 19);
        hi = sh_dly + sh_dur;
        if (sel < 15 && sh_dly < TMAX)
            return sh_dly + 1 + ($urandom % ((hi > TMAX ? TMAX : hi - 1) - sh_dly > 0 ?
                   (hi > TMAX ? TMAX : hi - 1) - sh_dly : 1));
        else if (sel < 17)
            return sh_dly;
        else if (sel < 18 && hi <= TMAX)
            return hi;
        else
            return $urandom_range(0, 24'hFFFFFF);
    endfunction

    row_t rows[$];

    initial
    begin
        static row_t r;
        longint dur, dly;
        logic [4:0] crv;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; elapsed_time = '0; out_ready = 1'b0;
        use_typed = 1'b0; typed_frame = '0; quiet = 1'b0;
        n_err = 0; n_frames = 0; n_items = 0; stall_left = 0;
        sh_dur = 1; sh_dly = 0; sh_crv = CRV_LINEAR; sh_done = 1'b0;

        // Directed rows: reset state, window edges, every curve, corner cases
        rows.push_back('{1, 0, CRV_LINEAR, 0, 1, '{1'b0, 1'b0, 18'sd0}});
        rows.push_back('{1000, 100, CRV_LINEAR, 100, 1, '{1'b0, 1'b0, 18'sd0}});
        rows.push_back('{1000, 100, CRV_LINEAR, 600, 1, '{1'b1, 1'b0, 18'sd32768}});
        rows.push_back('{TMAX, 0, CRV_EXPO_IN, 1, 1, '{1'b1, 1'b0, 18'sd0}});
        rows.push_back('{TMAX, 0, CRV_EXPO_INOUT, 1, 1, '{1'b1, 1'b0, 18'sd0}});
        for (int c = 1; c <= 21; c++)
            rows.push_back('{1000, 100, curve_e'(c), 100 + 37 * c + (c % 3) * 200, 0, '0});
        rows.push_back('{1000, 100, CRV_UNKNOWN, 350, 0, '0});
        rows.push_back('{1000, 100, CRV_LINEAR, 1100, 1, '{1'b0, 1'b1, 18'sd0}});
        rows.push_back('{1000, 100, CRV_LINEAR, 300, 1, '{1'b1, 1'b1, 18'sd13107}});
        rows.push_back('{0, 5, CRV_LINEAR, 6, 1, '{1'b0, 1'b1, 18'sd0}});
        rows.push_back('{TMAX, TMAX, CRV_BACK_IN, TMAX, 1, '{1'b0, 1'b1, 18'sd0}});
        rows.push_back('{TMAX, 0, CRV_LINEAR, TMAX, 1, '{1'b0, 1'b1, 18'sd0}});

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.dur != sh_dur || r.dly != sh_dly || r.crv != sh_crv)
                set_timing(r.dur, r.dly, r.crv);
            use_typed = r.typed;
            typed_frame = r.res;
            send_time(r.tm);
        end
        set_timing(1000, 100, CRV_LINEAR);
        use_typed = 1'b0;

        // Random phases; the last few run without gaps or stalls
        for (int ph = 0; ph < 22; ph++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    dur = $urandom_range(1, 24'hFFFFFF);
                2:       dur = ($urandom & 1) ? 1 : TMAX;
                default: dur = $urandom_range(1, 4000);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: dly = $urandom_range(0, 24'hFFFFFF);
                3:       dly = ($urandom & 1) ? 0 : TMAX;
                default: dly = $urandom_range(0, 2000);
            endcase
            crv = (ph < 20) ? 5'(ph + 1) : 5'($urandom_range(0, 31));
            if (ph == 0)
                crv = CRV_LINEAR;
            set_timing(dur, dly, crv);
            if (ph >= 19)
                quiet = 1'b1;
            repeat (25) send_time(pick_time());
        end

        wait_idle();
        $display("Covered %0d items, %0d frames over 22 curve codes plus unknown codes,",
                 n_items, n_frames);
        $display("random delays and durations incl. extremes, with gaps and stalls.");
        if (n_err == 0 && frame_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ecp_pkg.sv
sv/ecp_ctrl.sv
sv/ecp_dp.sv
sv/easing_curve_progress.sv
tb/easing_curve_progress_test.sv
